// ----- hw/rtl/tss_pkg.sv -----
// Shared types and constants for the trigger step sequencer.
// Used by tss_cv_addr and trigger_step_sequencer_core; depends on nothing.
`default_nettype none

package tss_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int MV_W       = 15;
  localparam int CV_MV_W    = 14;
  localparam int PATTERN_W  = 16;
  localparam int TICKS_W    = 16;
  localparam int REG_STEP_W = 5;

  // Largest step count or reset step that the five-bit registers can hold.
  localparam int REG_STEP_MAX = (1 << REG_STEP_W) - 1;

  localparam int MV_HIGH     = 1000;
  localparam int MV_FULL     = 10000;
  localparam int MV_CV_ENTRY = 11000;

  typedef logic signed [MV_W-1:0] mv_t;
  typedef logic [CV_MV_W-1:0]     cv_mv_t;
  typedef logic [CFG_IDX_W-1:0]   cfg_idx_t;
  typedef logic [CFG_DATA_W-1:0]  cfg_data_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_STEP_PATTERN     = 3'd0,
    REG_SEQ_LENGTH       = 3'd1,
    REG_RESET_STEP       = 3'd2,
    REG_ADDRESS_MODE     = 3'd3,
    REG_RUN_IS_TRIGGER   = 3'd4,
    REG_REVERSE_NEGATIVE = 3'd5,
    REG_PULSE_TICKS      = 3'd6
  } cfg_reg_t;

  typedef enum logic {
    MODE_CV    = 1'b0,
    MODE_CLOCK = 1'b1
  } addr_mode_t;

  typedef struct packed {
    logic [PATTERN_W-1:0]  step_pattern;
    logic [REG_STEP_W-1:0] seq_length;
    logic [REG_STEP_W-1:0] reset_step;
    addr_mode_t            address_mode;
    logic                  run_is_trigger;
    logic                  reverse_negative;
    logic [TICKS_W-1:0]    pulse_ticks;
  } cfg_t;

endpackage

`default_nettype wire

// ----- hw/rtl/tss_cv_addr.sv -----
// CV address decoder: maps a clamped 0 to 10 V level onto a one-based step address.
// Depends on tss_pkg for the voltage constants and types.
`default_nettype none

module tss_cv_addr #(
  parameter int LEN_MAX = 16
) (
  input  tss_pkg::cv_mv_t                    level_mv,
  input  logic [$clog2(LEN_MAX+1)-1:0]       len,
  output logic [$clog2(LEN_MAX+1)-1:0]       addr
);
  import tss_pkg::*;

  localparam int ADDR_W = $clog2(LEN_MAX + 1);
  localparam int PROD_W = CV_MV_W + ADDR_W;

  logic [PROD_W-1:0]  prod;
  logic [LEN_MAX-1:0] above;
  logic [ADDR_W-1:0]  quot;
  logic [ADDR_W:0]    addr_raw;

  // The quotient by full scale is the number of full-scale multiples that the
  // product reaches, found by parallel compares against constant thresholds.
  assign prod = PROD_W'(level_mv) * PROD_W'(len);

  always_comb begin
    for (int k = 0; k < LEN_MAX; k++) begin
      above[k] = prod >= PROD_W'((k + 1) * MV_FULL);
    end
  end

  assign quot     = ADDR_W'($countones(above));
  assign addr_raw = (ADDR_W + 1)'(quot) + 1'b1;
  assign addr     = (addr_raw >= (ADDR_W + 1)'(len)) ? len : addr_raw[ADDR_W-1:0];

endmodule

`default_nettype wire

// ----- hw/rtl/trigger_step_sequencer_core.sv -----
// Trigger step sequencer core: run control, clocked and CV step addressing, trigger pulse.
// Depends on tss_pkg and instantiates tss_cv_addr.
//
// One request on the item channel is one sample tick carrying the clock, reverse,
// run and reset voltages and the run patch and button levels. Each request yields
// exactly one request on the result channel with the gate level, the zero-based
// step and the run state after that tick.
// A request is taken at a rising edge with item_valid high and item_stall low. It
// is held in an input register, and its result is registered in the result register
// once that register can advance. A new request can be taken in every cycle while
// the result channel does not stall: the whole tick is one pass of logic between the
// input register and the result register, and the sequencer state is written in that same pass.
// When the receiver raises result_stall, the result register holds. An empty input
// register still takes one request; item_stall is high whenever the input register
// is full while the result waits, and it drops in the cycle the result is taken.
// The user must write configuration via cfg_we, cfg_index and cfg_data while the
// block is idle; the block does not enforce this. Synchronous reset restores the
// register defaults, sets step 0, running, clocked mode and no pulse, and empties both registers.
`default_nettype none

module trigger_step_sequencer_core #(
  parameter int MAX_STEPS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  tss_pkg::cfg_idx_t  cfg_index,
  input  tss_pkg::cfg_data_t cfg_data,
  input  logic               item_valid,
  output logic               item_stall,
  input  tss_pkg::mv_t       clock_mv,
  input  tss_pkg::mv_t       reverse_mv,
  input  tss_pkg::mv_t       run_mv,
  input  tss_pkg::mv_t       reset_mv,
  input  logic               run_connected,
  input  logic               run_button,
  output logic               result_valid,
  input  logic               result_stall,
  output logic               gate_out,
  output logic [3:0]         current_step,
  output logic               running
);
  import tss_pkg::*;

  localparam int LEN_MAX = (MAX_STEPS > REG_STEP_MAX) ? REG_STEP_MAX : MAX_STEPS;
  localparam int IDX_W   = $clog2(LEN_MAX);
  localparam int ADDR_W  = $clog2(LEN_MAX + 1);

  cfg_t cfg;

  logic              in_valid;
  mv_t               in_clock_mv;
  mv_t               in_reverse_mv;
  mv_t               in_run_mv;
  mv_t               in_reset_mv;
  logic              in_run_connected;
  logic              in_run_button;

  logic [IDX_W-1:0]  step_index;
  logic              run_state;
  mv_t               prev_clock_mv;
  logic              prev_reset_high;
  logic              prev_run_high;
  logic [ADDR_W-1:0] prev_address;
  addr_mode_t        prev_mode;
  logic              pulse_active;
  logic [TICKS_W-1:0] pulse_left;

  logic [IDX_W-1:0]  step_index_next;
  logic              run_state_next;
  mv_t               prev_clock_mv_next;
  logic              prev_reset_high_next;
  logic              prev_run_high_next;
  logic [ADDR_W-1:0] prev_address_next;
  addr_mode_t        prev_mode_next;
  logic              pulse_active_next;
  logic [TICKS_W-1:0] pulse_left_next;
  logic              gate_next;

  logic              advance;
  logic              accept;
  logic              fire;
  logic [ADDR_W-1:0] len;
  logic [ADDR_W-1:0] rs;
  logic [ADDR_W-1:0] step_inc;
  logic [5:0]        idx_wide;
  logic              backward;
  logic              rhigh;
  cv_mv_t            level_mv;
  logic [ADDR_W-1:0] cv_addr;

  assign advance    = !result_valid || !result_stall;
  assign item_stall = in_valid && !advance;
  assign accept     = item_valid && !item_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.step_pattern     <= '0;
      cfg.seq_length       <= REG_STEP_W'(16);
      cfg.reset_step       <= REG_STEP_W'(1);
      cfg.address_mode     <= MODE_CLOCK;
      cfg.run_is_trigger   <= 1'b0;
      cfg.reverse_negative <= 1'b0;
      cfg.pulse_ticks      <= TICKS_W'(48);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_STEP_PATTERN:     cfg.step_pattern     <= cfg_data[PATTERN_W-1:0];
        REG_SEQ_LENGTH:       cfg.seq_length       <= cfg_data[REG_STEP_W-1:0];
        REG_RESET_STEP:       cfg.reset_step       <= cfg_data[REG_STEP_W-1:0];
        REG_ADDRESS_MODE:     cfg.address_mode     <= addr_mode_t'(cfg_data[0]);
        REG_RUN_IS_TRIGGER:   cfg.run_is_trigger   <= cfg_data[0];
        REG_REVERSE_NEGATIVE: cfg.reverse_negative <= cfg_data[0];
        REG_PULSE_TICKS:      cfg.pulse_ticks      <= cfg_data[TICKS_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (accept) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_clock_mv      <= clock_mv;
      in_reverse_mv    <= reverse_mv;
      in_run_mv        <= run_mv;
      in_reset_mv      <= reset_mv;
      in_run_connected <= run_connected;
      in_run_button    <= run_button;
    end
  end

  always_comb begin
    if (cfg.seq_length == '0) begin
      len = ADDR_W'(1);
    end else if (int'(cfg.seq_length) > LEN_MAX) begin
      len = ADDR_W'(LEN_MAX);
    end else begin
      len = ADDR_W'(cfg.seq_length);
    end
    if (cfg.reset_step == '0) begin
      rs = ADDR_W'(1);
    end else if (int'(cfg.reset_step) > LEN_MAX) begin
      rs = ADDR_W'(LEN_MAX);
    end else begin
      rs = ADDR_W'(cfg.reset_step);
    end
  end

  always_comb begin
    if (in_clock_mv > mv_t'(MV_FULL)) begin
      level_mv = cv_mv_t'(MV_FULL);
    end else if (in_clock_mv < 0) begin
      level_mv = '0;
    end else begin
      level_mv = in_clock_mv[CV_MV_W-1:0];
    end
  end

  tss_cv_addr #(
    .LEN_MAX (LEN_MAX)
  ) u_cv_addr (
    .level_mv (level_mv),
    .len      (len),
    .addr     (cv_addr)
  );

  assign rhigh    = in_reset_mv >= mv_t'(MV_HIGH);
  assign backward = cfg.reverse_negative ? (in_reverse_mv < -mv_t'(MV_HIGH))
                                         : (in_reverse_mv >= mv_t'(MV_HIGH));

  always_comb begin
    step_index_next      = step_index;
    run_state_next       = run_state;
    prev_clock_mv_next   = prev_clock_mv;
    prev_reset_high_next = prev_reset_high;
    prev_run_high_next   = prev_run_high;
    prev_address_next    = prev_address;
    prev_mode_next       = prev_mode;
    pulse_active_next    = pulse_active;
    pulse_left_next      = pulse_left;
    gate_next            = 1'b0;
    fire                 = 1'b0;
    step_inc             = '0;

    if (in_run_connected) begin
      if (!cfg.run_is_trigger) begin
        run_state_next = in_run_mv > mv_t'(MV_HIGH);
      end else begin
        if ((in_run_mv > mv_t'(MV_HIGH)) && !prev_run_high) begin
          run_state_next = !run_state;
        end
        prev_run_high_next = in_run_mv > mv_t'(MV_HIGH);
      end
    end else begin
      run_state_next = in_run_button;
    end

    if (run_state_next) begin
      if (cfg.address_mode == MODE_CV && prev_mode == MODE_CLOCK) begin
        prev_clock_mv_next = mv_t'(MV_CV_ENTRY);
        prev_address_next  = '0;
      end
      prev_mode_next = cfg.address_mode;

      if (cfg.address_mode == MODE_CLOCK) begin
        if (rhigh && !prev_reset_high) begin
          step_index_next = IDX_W'(rs - 1'b1);
        end
        prev_reset_high_next = rhigh;
        if (in_clock_mv >= mv_t'(MV_HIGH) && prev_clock_mv < mv_t'(MV_HIGH)) begin
          if (!backward) begin
            step_inc = ADDR_W'(step_index_next) + 1'b1;
            step_index_next = (step_inc >= len) ? '0 : IDX_W'(step_inc);
          end else if (step_index_next == '0) begin
            step_index_next = IDX_W'(len - 1'b1);
          end else begin
            step_index_next = step_index_next - 1'b1;
          end
          fire = 1'b1;
        end
        prev_clock_mv_next = in_clock_mv;
      end else begin
        if (mv_t'(level_mv) != prev_clock_mv_next && cv_addr != prev_address_next) begin
          step_index_next   = IDX_W'(cv_addr - 1'b1);
          prev_address_next = cv_addr;
          fire              = 1'b1;
        end
        prev_clock_mv_next = mv_t'(level_mv);
      end
    end

    // Steps beyond the pattern width never fire.
    idx_wide = 6'(step_index_next);
    if (fire && idx_wide < 6'(PATTERN_W) && cfg.step_pattern[idx_wide[3:0]]) begin
      pulse_active_next = 1'b1;
      pulse_left_next   = cfg.pulse_ticks;
    end

    if (pulse_active_next) begin
      if (pulse_left_next == '0) begin
        pulse_active_next = 1'b0;
      end else begin
        pulse_left_next = pulse_left_next - 1'b1;
        gate_next       = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step_index      <= '0;
      run_state       <= 1'b1;
      prev_clock_mv   <= '0;
      prev_reset_high <= 1'b0;
      prev_run_high   <= 1'b0;
      prev_address    <= '0;
      prev_mode       <= MODE_CLOCK;
      pulse_active    <= 1'b0;
      pulse_left      <= '0;
      result_valid    <= 1'b0;
    end else if (in_valid && advance) begin
      step_index      <= step_index_next;
      run_state       <= run_state_next;
      prev_clock_mv   <= prev_clock_mv_next;
      prev_reset_high <= prev_reset_high_next;
      prev_run_high   <= prev_run_high_next;
      prev_address    <= prev_address_next;
      prev_mode       <= prev_mode_next;
      pulse_active    <= pulse_active_next;
      pulse_left      <= pulse_left_next;
      result_valid    <= 1'b1;
    end else if (!result_stall) begin
      result_valid    <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && advance) begin
      gate_out     <= gate_next;
      current_step <= 4'(step_index_next);
      running      <= run_state_next;
    end
  end

  a_running_matches_state: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> running == run_state)
    else $error("running output differs from the stored run state");

  a_step_in_range: assert property (@(posedge clk) disable iff (rst)
    int'(step_index) < LEN_MAX)
    else $error("step index beyond the largest step count");

  a_idle_pulse_clear: assert property (@(posedge clk) disable iff (rst)
    !pulse_active |-> pulse_left == '0)
    else $error("pulse counter left nonzero with no pulse active");

  a_stall_needs_item: assert property (@(posedge clk) disable iff (rst)
    item_stall |-> in_valid && result_valid)
    else $error("item channel stalled with room in the pipeline");

endmodule

`default_nettype wire

// ----- dv/tss_scoreboard_pkg.sv -----
// Scoreboard for the trigger step sequencer: tick and result types and a class that
// predicts the gate, step and run outputs of each tick and checks them in order.
// Depends on tss_pkg for the register, mode and voltage types.
package tss_scoreboard_pkg;

  import tss_pkg::*;

  typedef struct packed {
    mv_t  clock_mv;
    mv_t  reverse_mv;
    mv_t  run_mv;
    mv_t  reset_mv;
    logic run_connected;
    logic run_button;
  } tick_t;

  typedef struct packed {
    logic       gate_out;
    logic [3:0] current_step;
    logic       running;
  } step_out_t;

  class tick_scoreboard;
    cfg_t       regs;
    int         step_idx;
    bit         run_on;
    int         last_clock_mv;
    bit         last_reset_hi;
    bit         last_run_hi;
    int         last_addr;
    addr_mode_t last_mode;
    bit         pulse_on;
    int         pulse_cnt;
    step_out_t  expected_outs[$];
    int         errors;

    function new();
      regs.step_pattern     = '0;
      regs.seq_length       = 5'd16;
      regs.reset_step       = 5'd1;
      regs.address_mode     = MODE_CLOCK;
      regs.run_is_trigger   = 1'b0;
      regs.reverse_negative = 1'b0;
      regs.pulse_ticks      = 16'd48;
      step_idx      = 0;
      run_on        = 1'b1;
      last_clock_mv = 0;
      last_reset_hi = 1'b0;
      last_run_hi   = 1'b0;
      last_addr     = 0;
      last_mode     = MODE_CLOCK;
      pulse_on      = 1'b0;
      pulse_cnt     = 0;
      errors        = 0;
    endfunction

    function void write_reg(cfg_reg_t idx, cfg_data_t val);
      case (idx)
        REG_STEP_PATTERN:     regs.step_pattern = val;
        REG_SEQ_LENGTH:       regs.seq_length = val[REG_STEP_W-1:0];
        REG_RESET_STEP:       regs.reset_step = val[REG_STEP_W-1:0];
        REG_ADDRESS_MODE:     regs.address_mode = addr_mode_t'(val[0]);
        REG_RUN_IS_TRIGGER:   regs.run_is_trigger = val[0];
        REG_REVERSE_NEGATIVE: regs.reverse_negative = val[0];
        REG_PULSE_TICKS:      regs.pulse_ticks = val;
        default: ;
      endcase
    endfunction

    function void fire_if_set();
      if (step_idx < PATTERN_W && regs.step_pattern[step_idx]) begin
        pulse_on  = 1'b1;
        pulse_cnt = int'(regs.pulse_ticks);
      end
    endfunction

    function void note_tick(tick_t t);
      step_out_t r;
      int  clk_v, rev_v, run_v, rst_v, len, rs, c, addr;
      bit  hi, rhigh, backward;
      clk_v = int'(t.clock_mv);
      rev_v = int'(t.reverse_mv);
      run_v = int'(t.run_mv);
      rst_v = int'(t.reset_mv);
      r.gate_out = 1'b0;

      if (t.run_connected) begin
        hi = run_v > MV_HIGH;
        if (!regs.run_is_trigger) begin
          run_on = hi;
        end else begin
          if (hi && !last_run_hi) run_on = !run_on;
          last_run_hi = hi;
        end
      end else begin
        run_on = t.run_button;
      end

      if (run_on) begin
        len = int'(regs.seq_length);
        if (len < 1) len = 1;
        if (len > 16) len = 16;
        if (regs.address_mode == MODE_CV && last_mode == MODE_CLOCK) begin
          last_clock_mv = MV_CV_ENTRY;
          last_addr     = 0;
        end
        last_mode = regs.address_mode;

        if (regs.address_mode == MODE_CLOCK) begin
          rhigh = rst_v >= MV_HIGH;
          if (rhigh && !last_reset_hi) begin
            rs = int'(regs.reset_step);
            if (rs < 1) rs = 1;
            if (rs > 16) rs = 16;
            step_idx = rs - 1;
          end
          last_reset_hi = rhigh;
          if (clk_v >= MV_HIGH && last_clock_mv < MV_HIGH) begin
            backward = regs.reverse_negative ? (rev_v < -MV_HIGH) : (rev_v >= MV_HIGH);
            if (!backward) begin
              step_idx++;
              if (step_idx >= len) step_idx = 0;
            end else if (step_idx == 0) begin
              step_idx = len - 1;
            end else begin
              step_idx--;
            end
            fire_if_set();
          end
          last_clock_mv = clk_v;
        end else begin
          c = clk_v;
          if (c > MV_FULL) c = MV_FULL;
          else if (c < 0) c = 0;
          if (c != last_clock_mv) begin
            addr = (c * len) / MV_FULL + 1;
            if (addr >= len) addr = len;
            if (addr != last_addr) begin
              step_idx = addr - 1;
              fire_if_set();
              last_addr = addr;
            end
          end
          last_clock_mv = c;
        end
      end

      if (pulse_on) begin
        if (pulse_cnt == 0) begin
          pulse_on = 1'b0;
        end else begin
          pulse_cnt--;
          r.gate_out = 1'b1;
        end
      end
      r.current_step = step_idx[3:0];
      r.running      = run_on;
      expected_outs.push_back(r);
    endfunction

    function void check_result(step_out_t got);
      step_out_t exp_r;
      if (expected_outs.size() == 0) begin
        $display("%0t: result with no tick pending: gate %b step %0d running %b",
                 $time, got.gate_out, got.current_step, got.running);
        errors++;
        return;
      end
      exp_r = expected_outs.pop_front();
      if (got.gate_out !== exp_r.gate_out) begin
        $display("%0t: gate_out expected %b actual %b", $time, exp_r.gate_out, got.gate_out);
        errors++;
      end
      if (got.current_step !== exp_r.current_step) begin
        $display("%0t: current_step expected %0d actual %0d",
                 $time, exp_r.current_step, got.current_step);
        errors++;
      end
      if (got.running !== exp_r.running) begin
        $display("%0t: running expected %b actual %b", $time, exp_r.running, got.running);
        errors++;
      end
    endfunction

    function int pending();
      return expected_outs.size();
    endfunction
  endclass

endpackage

// ----- dv/tb_trigger_step_sequencer_core.sv -----
// Top-level testbench for trigger_step_sequencer_core: directed and random ticks under
// random idling on both channels, with results checked by tick_scoreboard.
// Depends on tss_pkg, tss_scoreboard_pkg and the sequencer RTL.
module tb_trigger_step_sequencer_core;
  timeunit 1ns;
  timeprecision 1ps;

  import tss_pkg::*;
  import tss_scoreboard_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PHASE_TICKS    = 135;
  localparam int NUM_PHASES     = 8;
  localparam int LONG_HOLD      = 150;

  logic       clk = 1'b0;
  logic       rst;
  logic       cfg_we;
  cfg_idx_t   cfg_index;
  cfg_data_t  cfg_data;
  logic       item_valid;
  logic       item_stall;
  mv_t        clock_mv, reverse_mv, run_mv, reset_mv;
  logic       run_connected, run_button;
  logic       result_valid;
  logic       result_stall = 1'b0;
  logic       gate_out;
  logic [3:0] current_step;
  logic       running;

  tick_scoreboard sb;

  bit        item_fire_s, res_fire_s;
  tick_t     tick_s;
  step_out_t out_s;
  int        idle_cycles;

  bit         idle_on;
  bit         long_hold_req, long_hold_taken;
  int         hold_left, stall_left;
  addr_mode_t cur_mode;
  bit         cur_trig;
  bit         clk_hi, run_hi, rst_hi;
  mv_t        cv_level;

  trigger_step_sequencer_core u_top (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .item_valid    (item_valid),
    .item_stall    (item_stall),
    .clock_mv      (clock_mv),
    .reverse_mv    (reverse_mv),
    .run_mv        (run_mv),
    .reset_mv      (reset_mv),
    .run_connected (run_connected),
    .run_button    (run_button),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .gate_out      (gate_out),
    .current_step  (current_step),
    .running       (running)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Handshakes are sampled mid-cycle, where every signal has settled.
  always @(negedge clk) begin
    item_fire_s = !rst && item_valid && !item_stall;
    res_fire_s  = !rst && result_valid && !result_stall;
    tick_s = '{clock_mv, reverse_mv, run_mv, reset_mv, run_connected, run_button};
    out_s  = '{gate_out, current_step, running};
  end

  always @(posedge clk) begin
    if (item_fire_s) sb.note_tick(tick_s);
    if (res_fire_s) sb.check_result(out_s);
    if (rst || item_fire_s || res_fire_s) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no request accepted for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("TEST FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      if (long_hold_req && !long_hold_taken) begin
        long_hold_taken = 1'b1;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        result_stall <= 1'b1;
      end else if (idle_on && $urandom_range(7) == 0) begin
        stall_left = $urandom_range(9);
        result_stall <= 1'b1;
      end else begin
        result_stall <= 1'b0;
      end
    end
  end

  function automatic mv_t pick_mv(int lo, int hi);
    int r;
    r = $urandom_range(7);
    if (r == 0) return mv_t'(lo);
    if (r == 1) return mv_t'(hi);
    return mv_t'(lo + int'($urandom_range(hi - lo)));
  endfunction

  function automatic tick_t random_tick();
    tick_t t;
    if ($urandom_range(15) == 0) begin
      t.clock_mv      = mv_t'($urandom);
      t.reverse_mv    = mv_t'($urandom);
      t.run_mv        = mv_t'($urandom);
      t.reset_mv      = mv_t'($urandom);
      t.run_connected = 1'($urandom_range(1));
      t.run_button    = 1'($urandom_range(1));
      return t;
    end
    if (cur_mode == MODE_CLOCK) begin
      if ($urandom_range(1) == 1) clk_hi = !clk_hi;
      t.clock_mv = clk_hi ? pick_mv(MV_HIGH, 12000) : pick_mv(-12000, MV_HIGH - 1);
    end else begin
      if ($urandom_range(2) != 0) cv_level = pick_mv(-1500, 11500);
      t.clock_mv = cv_level;
    end
    case ($urandom_range(7))
      0: t.reverse_mv = mv_t'(-1001);
      1: t.reverse_mv = mv_t'(-1000);
      2: t.reverse_mv = mv_t'(999);
      3: t.reverse_mv = mv_t'(1000);
      default: t.reverse_mv = pick_mv(-12000, 12000);
    endcase
    if ($urandom_range(7) == 0) run_hi = !run_hi;
    if (!run_hi && !cur_trig && $urandom_range(2) == 0) run_hi = 1'b1;
    t.run_mv = run_hi ? pick_mv(MV_HIGH + 1, 12000) : pick_mv(-12000, MV_HIGH);
    if ($urandom_range(9) == 0) rst_hi = !rst_hi;
    t.reset_mv = rst_hi ? pick_mv(MV_HIGH, 12000) : pick_mv(-12000, MV_HIGH - 1);
    t.run_connected = ($urandom_range(9) != 0);
    t.run_button    = ($urandom_range(3) != 0);
    return t;
  endfunction

  task automatic send_tick(tick_t t);
    if (idle_on && $urandom_range(7) == 0) begin
      item_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    item_valid    <= 1'b1;
    clock_mv      <= t.clock_mv;
    reverse_mv    <= t.reverse_mv;
    run_mv        <= t.run_mv;
    reset_mv      <= t.reset_mv;
    run_connected <= t.run_connected;
    run_button    <= t.run_button;
    do @(posedge clk); while (!item_fire_s);
  endtask

  task automatic send_fixed(int c, int rv, int rn, int rs, bit conn, bit btn);
    send_tick('{mv_t'(c), mv_t'(rv), mv_t'(rn), mv_t'(rs), conn, btn});
  endtask

  task automatic drain();
    item_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() > 0);
  endtask

  task automatic write_reg(cfg_reg_t idx, cfg_data_t val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    sb.write_reg(idx, val);
  endtask

  task automatic configure(cfg_data_t pattern, int len, int rstep, addr_mode_t mode,
                           bit trig, bit revneg, cfg_data_t ticks);
    drain();
    write_reg(REG_STEP_PATTERN, pattern);
    write_reg(REG_SEQ_LENGTH, cfg_data_t'(len));
    write_reg(REG_RESET_STEP, cfg_data_t'(rstep));
    write_reg(REG_ADDRESS_MODE, cfg_data_t'(mode));
    write_reg(REG_RUN_IS_TRIGGER, cfg_data_t'(trig));
    write_reg(REG_REVERSE_NEGATIVE, cfg_data_t'(revneg));
    write_reg(REG_PULSE_TICKS, ticks);
    cfg_we   <= 1'b0;
    cur_mode = mode;
    cur_trig = trig;
  endtask

  initial begin
    rst           = 1'b1;
    cfg_we        = 1'b0;
    cfg_index     = REG_STEP_PATTERN;
    cfg_data      = '0;
    item_valid    = 1'b0;
    clock_mv      = '0;
    reverse_mv    = '0;
    run_mv        = '0;
    reset_mv      = '0;
    run_connected = 1'b0;
    run_button    = 1'b0;
    idle_on       = 1'b1;
    run_hi        = 1'b1;
    sb = new();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    configure(16'hFFFF, 4, 3, MODE_CLOCK, 1'b0, 1'b0, 16'd2);
    send_fixed(0, 0, 5000, 0, 1'b1, 1'b1);
    send_fixed(1000, 0, 5000, 0, 1'b1, 1'b1);
    send_fixed(999, 0, 5000, 0, 1'b1, 1'b1);
    send_fixed(12000, 1000, 5000, 0, 1'b1, 1'b1);
    send_fixed(-12000, 0, 5000, 0, 1'b1, 1'b1);
    send_fixed(16383, -16384, 5000, 0, 1'b1, 1'b1);
    send_fixed(-16384, 16383, 5000, 0, 1'b1, 1'b1);
    send_fixed(0, 0, 5000, 1000, 1'b1, 1'b1);
    send_fixed(1000, 0, 5000, 16383, 1'b1, 1'b1);
    send_fixed(0, 0, 5000, -12000, 1'b1, 1'b1);
    send_fixed(12000, 0, 5000, 0, 1'b1, 1'b1);
    send_fixed(0, 0, 1000, 0, 1'b1, 1'b1);
    send_fixed(12000, 0, 1001, 0, 1'b1, 1'b1);
    send_fixed(0, 0, -16384, 0, 1'b0, 1'b0);
    send_fixed(0, 0, 16383, 0, 1'b0, 1'b1);

    configure(16'hA5A5, 16, 1, MODE_CV, 1'b0, 1'b0, 16'd1);
    send_fixed(10000, 0, 5000, 0, 1'b1, 1'b1);
    send_fixed(0, 0, 5000, 0, 1'b1, 1'b1);
    send_fixed(-12000, 0, 5000, 0, 1'b1, 1'b1);
    send_fixed(11000, 0, 5000, 0, 1'b1, 1'b1);
    send_fixed(5000, 0, 5000, 0, 1'b1, 1'b1);
    send_fixed(5000, 0, 5000, 0, 1'b1, 1'b1);

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      case (phase)
        0: configure(cfg_data_t'($urandom), 16, 1, MODE_CLOCK, 1'b0, 1'b0, 16'd3);
        1: configure(16'hFFFF, 1, 16, MODE_CLOCK, 1'b1, 1'b1, 16'd1);
        2: configure(cfg_data_t'($urandom), 5, 9, MODE_CLOCK, 1'b0, 1'b1, 16'd0);
        3: configure(cfg_data_t'($urandom), 16, 1, MODE_CV, 1'b0, 1'b0, 16'd2);
        4: configure(cfg_data_t'($urandom), 0, 0, MODE_CV, 1'b1, 1'b0, 16'hFFFF);
        5: configure(cfg_data_t'($urandom), 31, 31, MODE_CLOCK, 1'b1, 1'b0, 16'd5);
        6: configure(16'h0000, 3, 2, MODE_CV, 1'b0, 1'b1, 16'd4);
        default: configure(cfg_data_t'($urandom), $urandom_range(1, 16),
                           $urandom_range(1, 16), MODE_CLOCK, 1'b0,
                           1'($urandom_range(1)), cfg_data_t'($urandom_range(1, 8)));
      endcase
      if (phase == 5) long_hold_req = 1'b1;
      if (phase == NUM_PHASES - 1) idle_on = 1'b0;
      for (int i = 0; i < PHASE_TICKS; i++) send_tick(random_tick());
    end

    drain();
    repeat (5) @(posedge clk);
    if (sb.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
